>>> rtl/slpg_pkg.sv
// shared types, codes and constants of the status led pattern generator
package slpg_pkg;

    localparam int LED_IDX_W = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int TIME_W = 32;
    localparam int FLAGS_W = 5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_INTERVAL = 2'd2;

    localparam logic [CFG_DATA_W-1:0] PULSE_INTERVAL_RST = 16'd10;
    localparam logic [CFG_DATA_W-1:0] BLINK_INTERVAL_RST = 16'd500;
    localparam logic [CFG_DATA_W-1:0] FLASH_INTERVAL_RST = 16'd100;

    // status flag bits
    localparam int FLAG_ERROR = 0;
    localparam int FLAG_INIT = 1;
    localparam int FLAG_STANDBY = 2;
    localparam int FLAG_MAINT = 3;
    localparam int FLAG_SHUTDOWN = 4;
    localparam logic [FLAGS_W-1:0] FLAGS_INIT_ONLY = 5'b00010;

    localparam logic MODE_UPDATE = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    localparam logic [7:0] STEP = 8'd5;
    localparam logic [7:0] LEVEL_MAX = 8'hFF;

    localparam logic [1:0] PHASE_RG = 2'd0;
    localparam logic [1:0] PHASE_GB = 2'd1;
    localparam logic [1:0] PHASE_BR = 2'd2;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    localparam rgb_t RGB_OFF = '{red: 8'h00, green: 8'h00, blue: 8'h00};
    localparam rgb_t RGB_RED = '{red: 8'hFF, green: 8'h00, blue: 8'h00};
    localparam rgb_t RGB_YELLOW = '{red: 8'hFF, green: 8'hFF, blue: 8'h00};
    localparam rgb_t RGB_DIM_GREEN = '{red: 8'h00, green: 8'h01, blue: 8'h00};

    typedef struct packed {
        logic                 mode;
        logic [TIME_W-1:0]    time_ms;
        logic                 user_control;
        logic                 host_alive;
        logic [FLAGS_W-1:0]   status_flags;
        logic [LED_IDX_W-1:0] color_index;
        logic [7:0]           red_in;
        logic [7:0]           green_in;
        logic [7:0]           blue_in;
    } item_t;

    typedef struct packed {
        logic [LED_IDX_W-1:0] led_index;
        logic [7:0]           red;
        logic [7:0]           green;
        logic [7:0]           blue;
        logic                 last_led;
    } result_t;

    function automatic logic [7:0] sat_up(input logic [7:0] v);
        logic [7:0] r;
        r = (v > (LEVEL_MAX - STEP)) ? LEVEL_MAX : v + STEP;
        return r;
    endfunction

    function automatic logic [7:0] sat_down(input logic [7:0] v);
        logic [7:0] r;
        r = (v < STEP) ? 8'd0 : v - STEP;
        return r;
    endfunction

endpackage

>>> rtl/slpg_led_chain.sv
// rotating per-led colour register chain with indexed write and shift-in
module slpg_led_chain #(
    parameter int NUM_LEDS = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [slpg_pkg::LED_IDX_W-1:0]     wr_idx,
    input  slpg_pkg::rgb_t                     wr_data,
    input  logic                               shift_en,
    input  slpg_pkg::rgb_t                     shift_data,
    input  logic                               rot_en,
    output slpg_pkg::rgb_t                     tap
);

    localparam int IW = slpg_pkg::LED_IDX_W;

    slpg_pkg::rgb_t ent_reg [NUM_LEDS];

    for (genvar i = 0; i < NUM_LEDS; i++) begin : g_ent
        localparam int NEXT = (i + 1) % NUM_LEDS;
        localparam int PREV = (i == 0) ? 0 : i - 1;

        slpg_pkg::rgb_t ent_next;

        always_comb
        begin
            ent_next = ent_reg[i];
            if (rot_en)
            begin
                // walk entries down one place, entry 0 wraps to the top
                ent_next = ent_reg[NEXT];
            end
            else if (shift_en)
            begin
                ent_next = (i == 0) ? shift_data : ent_reg[PREV];
            end
            else if (wr_en && (wr_idx == IW'(i)))
            begin
                ent_next = wr_data;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ent_reg[i] <= slpg_pkg::RGB_OFF;
            end
            else
            begin
                ent_reg[i] <= ent_next;
            end
        end
    end

    assign tap = ent_reg[0];

endmodule

>>> rtl/status_led_pattern_generator.sv
// top level of the status led pattern generator
//
//  channel  | signals                          | direction | word
//  ---------+----------------------------------+-----------+----------------------
//  item     | item_valid, item_ready, item     | in        | update or colour write
//  result   | result_valid, result_ready, res. | out       | one led colour
//  cfg      | cfg_we, cfg_index, cfg_data      | in        | interval registers
//
// an update is accepted, then the decide state picks the pattern and runs the
// shared elapsed-time compare, then one led word per cycle while result_ready
// is high leaves the single output register, read from the rotating colour chains.
// a colour write ends when accepted; an update that does not fire ends in decide.
// result_ready low holds the emit sequence; item_ready is low while busy.
// rst_n resets all pattern state, clears the colour tables and restores the interval defaults.
module status_led_pattern_generator #(
    parameter int NUM_LEDS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  slpg_pkg::item_t                   item,
    output logic                              result_valid,
    input  logic                              result_ready,
    output slpg_pkg::result_t                 result,
    input  logic                              cfg_we,
    input  logic [slpg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [slpg_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int IW = slpg_pkg::LED_IDX_W;
    localparam int TW = slpg_pkg::TIME_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_LEDS - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DECIDE = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    // colour source during emit
    localparam logic [1:0] SRC_USER = 2'd0;
    localparam logic [1:0] SRC_SWIRL = 2'd1;
    localparam logic [1:0] SRC_FILL = 2'd2;

    localparam logic [2:0] KIND_USER = 3'd0;
    localparam logic [2:0] KIND_FLASH = 3'd1;
    localparam logic [2:0] KIND_SWIRL = 3'd2;
    localparam logic [2:0] KIND_PULSE = 3'd3;
    localparam logic [2:0] KIND_BLINK = 3'd4;
    localparam logic [2:0] KIND_GREEN = 3'd5;

    logic [slpg_pkg::CFG_DATA_W-1:0] pulse_int_reg;
    logic [slpg_pkg::CFG_DATA_W-1:0] blink_int_reg;
    logic [slpg_pkg::CFG_DATA_W-1:0] flash_int_reg;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    slpg_pkg::item_t   item_reg;

    logic [7:0]        swirl_r_reg;
    logic [7:0]        swirl_g_reg;
    logic [7:0]        swirl_b_reg;
    logic [1:0]        swirl_phase_reg;
    logic [7:0]        pulse_level_reg;
    logic              pulse_falling_reg;
    logic [TW-1:0]     pulse_last_reg;
    logic              blink_lit_reg;
    logic [TW-1:0]     blink_last_reg;
    logic              flash_lit_reg;
    logic [TW-1:0]     flash_last_reg;

    logic [1:0]        src_reg;
    slpg_pkg::rgb_t    fill_rgb_reg;
    logic [IW-1:0]     led_cnt_reg;
    slpg_pkg::result_t result_reg;
    logic              result_valid_reg;

    logic              item_acc;
    logic              deciding;
    logic              load;
    logic              last_load;
    logic [slpg_pkg::FLAGS_W-1:0] flags_eff;
    logic [2:0]        kind;
    logic [TW-1:0]     cmp_last;
    logic [slpg_pkg::CFG_DATA_W-1:0] cmp_int;
    logic [TW-1:0]     elapsed;
    logic              fire;
    logic [7:0]        sat_a;
    logic [7:0]        sat_b;
    logic [7:0]        sat_a_up;
    logic [7:0]        sat_b_down;
    logic              phase_done;
    slpg_pkg::rgb_t    swirl_next;
    logic [1:0]        phase_next;
    logic [7:0]        level_next;
    slpg_pkg::rgb_t    user_tap;
    slpg_pkg::rgb_t    swirl_tap;
    slpg_pkg::rgb_t    emit_rgb;

    assign item_ready = (state_reg == ST_IDLE);
    assign item_acc = item_valid && item_ready;
    assign deciding = (state_reg == ST_DECIDE);
    assign load = (state_reg == ST_EMIT) && (!result_valid_reg || result_ready);
    assign last_load = load && (led_cnt_reg == LAST_IDX);

    // pattern priority
    always_comb
    begin
        flags_eff = item_reg.host_alive ? item_reg.status_flags : slpg_pkg::FLAGS_INIT_ONLY;
        if (item_reg.user_control)
        begin
            kind = KIND_USER;
        end
        else if (flags_eff[slpg_pkg::FLAG_ERROR])
        begin
            kind = KIND_FLASH;
        end
        else if (flags_eff[slpg_pkg::FLAG_INIT])
        begin
            kind = KIND_SWIRL;
        end
        else if (flags_eff[slpg_pkg::FLAG_STANDBY])
        begin
            kind = KIND_PULSE;
        end
        else if (flags_eff[slpg_pkg::FLAG_MAINT])
        begin
            kind = KIND_BLINK;
        end
        else if (flags_eff[slpg_pkg::FLAG_SHUTDOWN])
        begin
            kind = KIND_PULSE;
        end
        else
        begin
            kind = KIND_GREEN;
        end
    end

    // shared elapsed-time compare, modulo 2^32
    always_comb
    begin
        case (kind)
            KIND_FLASH:
            begin
                cmp_last = flash_last_reg;
                cmp_int = flash_int_reg;
            end
            KIND_BLINK:
            begin
                cmp_last = blink_last_reg;
                cmp_int = blink_int_reg;
            end
            default:
            begin
                cmp_last = pulse_last_reg;
                cmp_int = pulse_int_reg;
            end
        endcase
        elapsed = item_reg.time_ms - cmp_last;
        fire = (elapsed >= TW'(cmp_int));
    end

    // one saturating step pair for the colour wheel
    always_comb
    begin
        case (swirl_phase_reg)
            slpg_pkg::PHASE_RG:
            begin
                sat_a = swirl_r_reg;
                sat_b = swirl_g_reg;
            end
            slpg_pkg::PHASE_GB:
            begin
                sat_a = swirl_g_reg;
                sat_b = swirl_b_reg;
            end
            default:
            begin
                sat_a = swirl_b_reg;
                sat_b = swirl_r_reg;
            end
        endcase
        sat_a_up = slpg_pkg::sat_up(sat_a);
        sat_b_down = slpg_pkg::sat_down(sat_b);
        phase_done = (sat_a_up == slpg_pkg::LEVEL_MAX) && (sat_b_down == 8'd0);
        case (swirl_phase_reg)
            slpg_pkg::PHASE_RG:
            begin
                swirl_next = '{red: sat_a_up, green: sat_b_down, blue: swirl_b_reg};
                phase_next = phase_done ? slpg_pkg::PHASE_GB : swirl_phase_reg;
            end
            slpg_pkg::PHASE_GB:
            begin
                swirl_next = '{red: swirl_r_reg, green: sat_a_up, blue: sat_b_down};
                phase_next = phase_done ? slpg_pkg::PHASE_BR : swirl_phase_reg;
            end
            default:
            begin
                swirl_next = '{red: sat_b_down, green: swirl_g_reg, blue: sat_a_up};
                phase_next = phase_done ? slpg_pkg::PHASE_RG : swirl_phase_reg;
            end
        endcase
    end

    assign level_next = pulse_falling_reg ? pulse_level_reg - slpg_pkg::STEP
                                          : pulse_level_reg + slpg_pkg::STEP;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_acc && (item.mode == slpg_pkg::MODE_UPDATE))
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if ((kind == KIND_FLASH || kind == KIND_PULSE || kind == KIND_BLINK) && !fire)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (last_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_int_reg <= slpg_pkg::PULSE_INTERVAL_RST;
            blink_int_reg <= slpg_pkg::BLINK_INTERVAL_RST;
            flash_int_reg <= slpg_pkg::FLASH_INTERVAL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                slpg_pkg::CFG_PULSE_INTERVAL: pulse_int_reg <= cfg_data;
                slpg_pkg::CFG_BLINK_INTERVAL: blink_int_reg <= cfg_data;
                slpg_pkg::CFG_FLASH_INTERVAL: flash_int_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_acc)
        begin
            item_reg <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            swirl_r_reg <= 8'hFF;
            swirl_g_reg <= 8'h00;
            swirl_b_reg <= 8'h00;
            swirl_phase_reg <= slpg_pkg::PHASE_GB;
            pulse_level_reg <= 8'h00;
            pulse_falling_reg <= 1'b0;
            pulse_last_reg <= '0;
            blink_lit_reg <= 1'b0;
            blink_last_reg <= '0;
            flash_lit_reg <= 1'b0;
            flash_last_reg <= '0;
            src_reg <= SRC_FILL;
            fill_rgb_reg <= slpg_pkg::RGB_OFF;
            led_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (deciding)
            begin
                led_cnt_reg <= '0;
                case (kind)
                    KIND_USER:
                    begin
                        src_reg <= SRC_USER;
                    end
                    KIND_SWIRL:
                    begin
                        src_reg <= SRC_SWIRL;
                        swirl_r_reg <= swirl_next.red;
                        swirl_g_reg <= swirl_next.green;
                        swirl_b_reg <= swirl_next.blue;
                        swirl_phase_reg <= phase_next;
                    end
                    KIND_FLASH:
                    begin
                        src_reg <= SRC_FILL;
                        if (fire)
                        begin
                            fill_rgb_reg <= flash_lit_reg ? slpg_pkg::RGB_OFF : slpg_pkg::RGB_RED;
                            flash_lit_reg <= !flash_lit_reg;
                            flash_last_reg <= item_reg.time_ms;
                        end
                    end
                    KIND_BLINK:
                    begin
                        src_reg <= SRC_FILL;
                        if (fire)
                        begin
                            fill_rgb_reg <= blink_lit_reg ? slpg_pkg::RGB_OFF
                                                          : slpg_pkg::RGB_YELLOW;
                            blink_lit_reg <= !blink_lit_reg;
                            blink_last_reg <= item_reg.time_ms;
                        end
                    end
                    KIND_PULSE:
                    begin
                        src_reg <= SRC_FILL;
                        if (fire)
                        begin
                            fill_rgb_reg <= '{red: 8'h00, green: 8'h00, blue: level_next};
                            pulse_level_reg <= level_next;
                            // turn around at either end of the range
                            if (level_next == slpg_pkg::LEVEL_MAX || level_next == 8'h00)
                            begin
                                pulse_falling_reg <= !pulse_falling_reg;
                            end
                            pulse_last_reg <= item_reg.time_ms;
                        end
                    end
                    default:
                    begin
                        src_reg <= SRC_FILL;
                        fill_rgb_reg <= slpg_pkg::RGB_DIM_GREEN;
                    end
                endcase
            end
            else if (load)
            begin
                led_cnt_reg <= led_cnt_reg + IW'(1);
            end
        end
    end

    slpg_led_chain #(
        .NUM_LEDS   (NUM_LEDS)
    ) u_user_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (item_acc && (item.mode == slpg_pkg::MODE_WRITE)),
        .wr_idx     (item.color_index),
        .wr_data    ('{red: item.red_in, green: item.green_in, blue: item.blue_in}),
        .shift_en   (1'b0),
        .shift_data (slpg_pkg::RGB_OFF),
        .rot_en     (load && (src_reg == SRC_USER)),
        .tap        (user_tap)
    );

    slpg_led_chain #(
        .NUM_LEDS   (NUM_LEDS)
    ) u_swirl_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (1'b0),
        .wr_idx     ('0),
        .wr_data    (slpg_pkg::RGB_OFF),
        .shift_en   (deciding && (kind == KIND_SWIRL)),
        .shift_data (swirl_next),
        .rot_en     (load && (src_reg == SRC_SWIRL)),
        .tap        (swirl_tap)
    );

    always_comb
    begin
        case (src_reg)
            SRC_USER: emit_rgb = user_tap;
            SRC_SWIRL: emit_rgb = swirl_tap;
            default: emit_rgb = fill_rgb_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg.led_index <= led_cnt_reg;
            result_reg.red <= emit_rgb.red;
            result_reg.green <= emit_rgb.green;
            result_reg.blue <= emit_rgb.blue;
            result_reg.last_led <= (led_cnt_reg == LAST_IDX);
        end
    end

    assign result_valid = result_valid_reg;
    assign result = result_reg;

endmodule

>>> rtl/slpg_checker.sv
// port-level checks of the status led pattern generator and their bind
module slpg_checker #(
    parameter int NUM_LEDS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    input  logic                              item_ready,
    input  slpg_pkg::item_t                   item,
    input  logic                              result_valid,
    input  logic                              result_ready,
    input  slpg_pkg::result_t                 result,
    input  logic                              cfg_we,
    input  logic [slpg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [slpg_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int IW = slpg_pkg::LED_IDX_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_LEDS - 1);

    // a stalled word holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result word changed while stalled");

    // an update keeps the block busy on the next cycle
    a_update_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (item.mode == slpg_pkg::MODE_UPDATE) |=> !item_ready)
        else $error("item accepted again right after an update");

    // last flag marks exactly the final led of the chain
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.last_led == (result.led_index == LAST_IDX)))
        else $error("last_led does not match led_index");

    // led words within a frame come in order
    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && !result.last_led ##1 result_valid
        |-> result.led_index == $past(result.led_index) + IW'(1))
        else $error("led index out of sequence");

    // interval writes must come only while idle and drained; the block does not enforce it
    a_cfg_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |-> item_ready && !result_valid)
        else $error("interval register %0d written to %0h while busy", cfg_index, cfg_data);

endmodule

bind status_led_pattern_generator slpg_checker #(
    .NUM_LEDS (NUM_LEDS)
) u_slpg_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
);
